>>> rtl/core/sst_pkg.sv
package sst_pkg;

   localparam int SKY_RADIUS  = 378;
   localparam int SQRT_STAGES = 32;
   localparam int QUO_W       = 25;
   localparam int PROD_W      = 40;
   localparam int SCROLL_W    = 23;

   typedef enum logic [7:0] {
      CSR_VIEW_X   = 8'd0,
      CSR_VIEW_Y   = 8'd1,
      CSR_VIEW_Z   = 8'd2,
      CSR_TIME_NOW = 8'd3
   } sst_csr_type;

   // Data that rides along the square root pipeline.
   typedef struct packed {
      logic [PROD_W-1:0]   px;
      logic [PROD_W-1:0]   py;
      logic                sx;
      logic                sy;
      logic                degen;
      logic [SCROLL_W-1:0] scroll;
   } sst_sqrt_side_type;

   // Data that rides along the divider pipeline.
   typedef struct packed {
      logic                sx;
      logic                sy;
      logic                degen;
      logic [SCROLL_W-1:0] scroll;
   } sst_div_side_type;

endpackage

>>> rtl/core/sky_scroll_texcoord_gen.sv
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: vert_x, vert_y, vert_z; tuser: layer
// rsp       out        rsp_tvalid/rsp_tready  tdata: tex_s, tex_t; tuser: degenerate
// csr       in         csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One vertex enters per cycle while req_tready is high, that is while no skid entry is held.
// The path holds 64 register stages: six front stages, a 32-stage square root,
// a 25-stage divider and the output register.
// Reset is synchronous and clears valid bits and the view and time registers.
// A two-entry output buffer lets the pipeline keep moving into the skid entry when
// the output stalls; once that entry is full the whole pipeline holds, losing nothing.
module sky_scroll_texcoord_gen
   import sst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // vert_x [31:0], vert_y [63:32], vert_z [95:64]
   input  logic        req_tuser,   // layer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // tex_s [23:0], tex_t [47:24]
   output logic        rsp_tuser,   // degenerate
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] view_x_ff, view_y_ff, view_z_ff, time_now_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_x_ff   <= '0;
         view_y_ff   <= '0;
         view_z_ff   <= '0;
         time_now_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_VIEW_X:   view_x_ff   <= csr_data;
            CSR_VIEW_Y:   view_y_ff   <= csr_data;
            CSR_VIEW_Z:   view_z_ff   <= csr_data;
            CSR_TIME_NOW: time_now_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic out_v_ff, skid_v_ff;
   logic [47:0] out_data_ff, skid_data_ff;
   logic out_user_ff, skid_user_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   // Stage 0: differences and scroll.
   logic v0_ff;
   logic signed [32:0] dx0_ff, dy0_ff, dz0_ff;
   logic [SCROLL_W-1:0] scroll0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (en) v0_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx0_ff <= {req_tdata[31], req_tdata[31:0]} - {view_x_ff[31], view_x_ff};
         dy0_ff <= {req_tdata[63], req_tdata[63:32]} - {view_y_ff[31], view_y_ff};
         dz0_ff <= {req_tdata[95], req_tdata[95:64]} - {view_z_ff[31], view_z_ff};
         scroll0_ff <= req_tuser ? {time_now_ff[18:0], 4'b0000}
                                 : {time_now_ff[19:0], 3'b000};
      end
   end

   // Stage 1: magnitudes, height tripled.
   logic v1_ff, sx1_ff, sy1_ff;
   logic [34:0] ax1_ff, ay1_ff, az1_ff;
   logic [SCROLL_W-1:0] scroll1_ff;
   logic [32:0] mx, my, mz;

   always_comb begin
      mx = dx0_ff[32] ? 33'(-dx0_ff) : 33'(dx0_ff);
      my = dy0_ff[32] ? 33'(-dy0_ff) : 33'(dy0_ff);
      mz = dz0_ff[32] ? 33'(-dz0_ff) : 33'(dz0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= v0_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff     <= {2'b00, mx};
         ay1_ff     <= {2'b00, my};
         az1_ff     <= {1'b0, mz, 1'b0} + {2'b00, mz};
         sx1_ff     <= dx0_ff[32];
         sy1_ff     <= dy0_ff[32];
         scroll1_ff <= scroll0_ff;
      end
   end

   // Stage 2: leading one of the largest magnitude (same as that of the OR).
   logic v2_ff, sx2_ff, sy2_ff, degen2_ff;
   logic [34:0] ax2_ff, ay2_ff, az2_ff;
   logic [5:0] lead2_ff;
   logic [SCROLL_W-1:0] scroll2_ff;
   logic [34:0] any1;
   logic [5:0] lead;

   always_comb begin
      any1 = ax1_ff | ay1_ff | az1_ff;
      lead = '0;
      for (int i = 0; i < 35; i++) begin
         if (any1[i]) lead = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_ff     <= ax1_ff;
         ay2_ff     <= ay1_ff;
         az2_ff     <= az1_ff;
         lead2_ff   <= lead;
         degen2_ff  <= (any1 == '0);
         sx2_ff     <= sx1_ff;
         sy2_ff     <= sy1_ff;
         scroll2_ff <= scroll1_ff;
      end
   end

   // Stage 3: normalize so the largest lies in [2^30, 2^31).
   logic v3_ff, sx3_ff, sy3_ff, degen3_ff;
   logic [30:0] nx3_ff, ny3_ff, nz3_ff;
   logic [SCROLL_W-1:0] scroll3_ff;
   logic [65:0] wx, wy, wz;
   logic [5:0] nshift;

   always_comb begin
      nshift = lead2_ff + 6'd1;
      wx = {ax2_ff, 31'h0} >> nshift;
      wy = {ay2_ff, 31'h0} >> nshift;
      wz = {az2_ff, 31'h0} >> nshift;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx3_ff     <= wx[30:0];
         ny3_ff     <= wy[30:0];
         nz3_ff     <= wz[30:0];
         degen3_ff  <= degen2_ff;
         sx3_ff     <= sx2_ff;
         sy3_ff     <= sy2_ff;
         scroll3_ff <= scroll2_ff;
      end
   end

   // Stage 4: squares and radius products.
   logic v4_ff, sx4_ff, sy4_ff, degen4_ff;
   logic [61:0] qx4_ff, qy4_ff, qz4_ff;
   logic [PROD_W-1:0] px4_ff, py4_ff;
   logic [SCROLL_W-1:0] scroll4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qx4_ff     <= 62'(nx3_ff) * 62'(nx3_ff);
         qy4_ff     <= 62'(ny3_ff) * 62'(ny3_ff);
         qz4_ff     <= 62'(nz3_ff) * 62'(nz3_ff);
         px4_ff     <= PROD_W'(nx3_ff) * PROD_W'(SKY_RADIUS);
         py4_ff     <= PROD_W'(ny3_ff) * PROD_W'(SKY_RADIUS);
         degen4_ff  <= degen3_ff;
         sx4_ff     <= sx3_ff;
         sy4_ff     <= sy3_ff;
         scroll4_ff <= scroll3_ff;
      end
   end

   // Stage 5: sum of squares.
   logic v5_ff;
   logic [63:0] sum5_ff;
   sst_sqrt_side_type side5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum5_ff   <= {2'b00, qx4_ff} + {2'b00, qy4_ff} + {2'b00, qz4_ff};
         side5_ff  <= '{px: px4_ff, py: py4_ff, sx: sx4_ff, sy: sy4_ff,
                        degen: degen4_ff, scroll: scroll4_ff};
      end
   end

   logic sq_valid;
   logic [31:0] sq_root;
   sst_sqrt_side_type sq_side;

   sst_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_rad    (sum5_ff),
      .in_side   (side5_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic dv_valid;
   logic [QUO_W-1:0] dv_qx, dv_qy;
   sst_div_side_type dv_side;

   sst_div2 u_div2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_den    (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_side  (dv_side)
   );

   // Sign, scroll and floor division by 128 (an arithmetic shift).
   logic signed [25:0] hx, hy;
   logic signed [26:0] tsum_s, tsum_t;
   logic signed [19:0] cs, ct;
   logic [47:0] res_data;

   always_comb begin
      hx = dv_side.sx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      hy = dv_side.sy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
      tsum_s = $signed({4'b0000, dv_side.scroll}) + 27'(hx);
      tsum_t = $signed({4'b0000, dv_side.scroll}) + 27'(hy);
      cs = 20'(tsum_s >>> 7);
      ct = 20'(tsum_t >>> 7);
      if (dv_side.degen) res_data = '0;
      else res_data = {{4{ct[19]}}, ct, {4{cs[19]}}, cs};
   end

   logic take;
   assign take = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (dv_valid) begin
         if (out_v_ff && !take) skid_v_ff <= 1'b1;
         else out_v_ff <= 1'b1;
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
            out_user_ff <= skid_user_ff;
         end
      end else if (dv_valid) begin
         if (out_v_ff && !take) begin
            skid_data_ff <= res_data;
            skid_user_ff <= dv_side.degen;
         end else begin
            out_data_ff <= res_data;
            out_user_ff <= dv_side.degen;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without an output entry");

   a_skid_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid entry filled while output was free");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 48'h0))
      else $error("degenerate result with nonzero coordinates");

endmodule

>>> rtl/core/sst_isqrt.sv
module sst_isqrt
   import sst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       in_rad,
   input  sst_sqrt_side_type in_side,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output sst_sqrt_side_type out_side
);

   logic              valid_ff [0:SQRT_STAGES-1];
   logic [34:0]       rem_ff   [0:SQRT_STAGES-1];
   logic [31:0]       root_ff  [0:SQRT_STAGES-1];
   logic [63:0]       rad_ff   [0:SQRT_STAGES-1];
   sst_sqrt_side_type side_ff  [0:SQRT_STAGES-1];

   genvar k;
   generate
      for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
         logic              v_src;
         logic [34:0]       rem_src;
         logic [31:0]       root_src;
         logic [63:0]       rad_src;
         sst_sqrt_side_type side_src;
         logic [34:0]       rem_sh;
         logic [34:0]       trial;
         logic [34:0]       rem_in;
         logic [31:0]       root_in;

         if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = in_rad;
            assign side_src = in_side;
         end else begin : g_next
            assign v_src    = valid_ff[k-1];
            assign rem_src  = rem_ff[k-1];
            assign root_src = root_ff[k-1];
            assign rad_src  = rad_ff[k-1];
            assign side_src = side_ff[k-1];
         end

         // One result bit per stage: bring down two radicand bits, try 4*root+1.
         always_comb begin
            rem_sh = {rem_src[32:0], rad_src[63:62]};
            trial  = {1'b0, root_src, 2'b01};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_src[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_src[30:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               rad_ff[k]  <= {rad_src[61:0], 2'b00};
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

>>> rtl/core/sst_div2.sv
module sst_div2
   import sst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       in_den,
   input  sst_sqrt_side_type in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_qx,
   output logic [QUO_W-1:0]  out_qy,
   output sst_div_side_type  out_side
);

   // Numerator is product << 16; the quotient is known to fit QUO_W bits,
   // so the top bits start out as a partial remainder below the divisor.
   logic             valid_ff [0:QUO_W-1];
   logic [32:0]      remx_ff  [0:QUO_W-1];
   logic [32:0]      remy_ff  [0:QUO_W-1];
   logic [QUO_W-1:0] lox_ff   [0:QUO_W-1];
   logic [QUO_W-1:0] loy_ff   [0:QUO_W-1];
   logic [QUO_W-1:0] qx_ff    [0:QUO_W-1];
   logic [QUO_W-1:0] qy_ff    [0:QUO_W-1];
   logic [31:0]      den_ff   [0:QUO_W-1];
   sst_div_side_type side_ff  [0:QUO_W-1];

   genvar k;
   generate
      for (k = 0; k < QUO_W; k++) begin : g_stage
         logic             v_src;
         logic [32:0]      remx_src, remy_src;
         logic [QUO_W-1:0] lox_src, loy_src;
         logic [QUO_W-1:0] qx_src, qy_src;
         logic [31:0]      den_src;
         sst_div_side_type side_src;
         logic [32:0]      tx, ty;
         logic [32:0]      remx_in, remy_in;
         logic             bx, by;

         if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign remx_src = {2'b00, in_side.px[PROD_W-1:9]};
            assign remy_src = {2'b00, in_side.py[PROD_W-1:9]};
            assign lox_src  = {in_side.px[8:0], 16'h0000};
            assign loy_src  = {in_side.py[8:0], 16'h0000};
            assign qx_src   = '0;
            assign qy_src   = '0;
            assign den_src  = in_den;
            assign side_src = '{sx: in_side.sx, sy: in_side.sy,
                                degen: in_side.degen, scroll: in_side.scroll};
         end else begin : g_next
            assign v_src    = valid_ff[k-1];
            assign remx_src = remx_ff[k-1];
            assign remy_src = remy_ff[k-1];
            assign lox_src  = lox_ff[k-1];
            assign loy_src  = loy_ff[k-1];
            assign qx_src   = qx_ff[k-1];
            assign qy_src   = qy_ff[k-1];
            assign den_src  = den_ff[k-1];
            assign side_src = side_ff[k-1];
         end

         always_comb begin
            tx = {remx_src[31:0], lox_src[QUO_W-1]};
            ty = {remy_src[31:0], loy_src[QUO_W-1]};
            bx = (tx >= {1'b0, den_src});
            by = (ty >= {1'b0, den_src});
            remx_in = bx ? (tx - {1'b0, den_src}) : tx;
            remy_in = by ? (ty - {1'b0, den_src}) : ty;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               remx_ff[k] <= remx_in;
               remy_ff[k] <= remy_in;
               lox_ff[k]  <= {lox_src[QUO_W-2:0], 1'b0};
               loy_ff[k]  <= {loy_src[QUO_W-2:0], 1'b0};
               qx_ff[k]   <= {qx_src[QUO_W-2:0], bx};
               qy_ff[k]   <= {qy_src[QUO_W-2:0], by};
               den_ff[k]  <= den_src;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[QUO_W-1];
   assign out_qx    = qx_ff[QUO_W-1];
   assign out_qy    = qy_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
